// ----- rtl/core/rtha_pkg.sv -----
// Shared types and constants of the record table heap allocator.
package rtha_pkg;

   localparam int REQ_W    = 13;
   localparam int OFF_W    = 12;
   localparam int REQ_TD_W = 32;
   localparam int RSP_TD_W = 16;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SIZE,
      ST_ATTEMPT,
      ST_SCAN,
      ST_RESP
   } state_type;

endpackage

// ----- rtl/core/record_table_heap_allocator.sv -----
// Record table heap allocator: first-fit region placement over a record memory.
// Free: one pass over the record memory from request to result.
// Allocate (with a free record): size rounding (reciprocal multiply, then scale), then
// up to RECORDS placement attempts. One request at a time; the result register frees
// the input side once loaded. Synchronous reset clears all busy bits, the control state
// and the result valid flag; the record memory needs no clearing.
module record_table_heap_allocator
   import rtha_pkg::*;
#(
   parameter int RECORDS    = 16,
   parameter int HEAP_WORDS = 1024,
   parameter int WORD_BYTES = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [REQ_TD_W-1:0] req_tdata,   // req_bytes[12:0], free_offset[24:13], zero fill
   input  logic                req_tuser,   // mode
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [RSP_TD_W-1:0] rsp_tdata    // ok[0], region_offset[12:1], zero fill
);

   localparam int HEAP_BYTES = HEAP_WORDS * WORD_BYTES;
   localparam int IW  = $clog2(RECORDS);
   localparam int CW  = $clog2(RECORDS + 1);
   localparam int SW  = $clog2(HEAP_BYTES + 1);
   localparam int AW  = $clog2(HEAP_BYTES + 16384);
   localparam int RND_W = REQ_W + 1;
   localparam int RSH   = RND_W + 3;
   localparam int RECIP = (2**RSH + WORD_BYTES - 1) / WORD_BYTES;
   localparam logic [AW-1:0]    HEAP_LIM = AW'(HEAP_BYTES);
   localparam logic [AW-1:0]    WB_A     = AW'(WORD_BYTES);
   localparam logic [RND_W-1:0] WB_M1    = RND_W'(WORD_BYTES - 1);
   localparam logic [RSH:0]     RECIP_C  = (RSH + 1)'(RECIP);
   localparam logic [IW-1:0]    LAST_IDX = IW'(RECORDS - 1);
   localparam logic [CW-1:0]    REC_CNT  = CW'(RECORDS);

   state_type state_ff, state_in;

   logic [2*SW-1:0] mem [RECORDS];
   logic [2*SW-1:0] rdata_ff;
   logic            mem_we;
   logic            rd_en;

   logic [RECORDS-1:0] busy_ff, busy_in;
   logic               mode_ff, mode_in;
   logic [REQ_W-1:0]   req_ff, req_in;
   logic [OFF_W-1:0]   foff_ff, foff_in;
   logic               bit_ff, bit_in;
   logic [AW-1:0]      size_ff, size_in;
   logic [AW-1:0]      s_ff, s_in;
   logic [AW-1:0]      e_ff, e_in;
   logic [IW-1:0]      slot_ff, slot_in;
   logic [CW-1:0]      att_ff, att_in;
   logic [CW-1:0]      iss_ff, iss_in;
   logic               pend_ff, pend_in;
   logic [IW-1:0]      tag_ff, tag_in;
   logic               ok_ff, ok_in;
   logic [OFF_W-1:0]   off_ff, off_in;
   logic               rsp_valid_ff;
   logic [OFF_W-1:0]   rsp_off_ff;
   logic               rsp_ok_ff;
   logic               rsp_load;

   logic [IW-1:0]        free_slot;
   logic                 any_free;
   logic [RND_W-1:0]     rnd;
   logic [RND_W+RSH:0]   prod;
   logic [AW-1:0]        quot;
   logic [AW-1:0]        rs, re;
   logic                 hit;

   always_comb begin
      free_slot = '0;
      any_free  = 1'b0;
      for (int i = RECORDS - 1; i >= 0; i--) begin
         if (!busy_ff[i]) begin
            free_slot = IW'(i);
            any_free  = 1'b1;
         end
      end
   end

   // word count = ceil(bytes / WORD_BYTES) by reciprocal multiply
   assign rnd  = {1'b0, req_ff} + WB_M1;
   assign prod = {{(RSH + 1){1'b0}}, rnd} * {{RND_W{1'b0}}, RECIP_C};
   assign quot = AW'(prod[RND_W+RSH:RSH]);

   assign rs = AW'(rdata_ff[2*SW-1:SW]);
   assign re = AW'(rdata_ff[SW-1:0]);

   always_comb begin
      if (mode_ff == MODE_FREE) begin
         hit = pend_ff && busy_ff[tag_ff] && (rs == AW'(foff_ff));
      end else begin
         hit = pend_ff && busy_ff[tag_ff] &&
               ((s_ff <= rs && e_ff >= rs) || (s_ff <= re && e_ff >= re) ||
                (s_ff >= rs && e_ff <= re));
      end
   end

   always_comb begin
      state_in = state_ff;
      busy_in  = busy_ff;
      mode_in  = mode_ff;
      req_in   = req_ff;
      foff_in  = foff_ff;
      bit_in   = bit_ff;
      size_in  = size_ff;
      s_in     = s_ff;
      e_in     = e_ff;
      slot_in  = slot_ff;
      att_in   = att_ff;
      iss_in   = iss_ff;
      pend_in  = 1'b0;
      tag_in   = tag_ff;
      ok_in    = ok_ff;
      off_in   = off_ff;
      mem_we   = 1'b0;
      rd_en    = 1'b0;
      rsp_load = 1'b0;
      req_tready = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               mode_in = req_tuser;
               req_in  = req_tdata[REQ_W-1:0];
               foff_in = req_tdata[REQ_W+OFF_W-1:REQ_W];
               slot_in = free_slot;
               bit_in  = 1'b0;
               s_in    = '0;
               att_in  = '0;
               iss_in  = '0;
               ok_in   = 1'b0;
               off_in  = '0;
               if (req_tuser == MODE_FREE) begin
                  state_in = ST_SCAN;
               end else if (!any_free) begin
                  state_in = ST_RESP;
               end else begin
                  state_in = ST_SIZE;
               end
            end
         end
         ST_SIZE: begin
            bit_in = 1'b1;
            if (!bit_ff) begin
               size_in = quot;
            end else begin
               size_in  = size_ff * WB_A;
               e_in     = size_ff * WB_A;
               state_in = ST_ATTEMPT;
            end
         end
         ST_ATTEMPT: begin
            iss_in = '0;
            if (att_ff == REC_CNT || e_ff > HEAP_LIM) begin
               state_in = ST_RESP;
            end else begin
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (iss_ff < REC_CNT) begin
               rd_en   = 1'b1;
               pend_in = 1'b1;
               tag_in  = iss_ff[IW-1:0];
               iss_in  = iss_ff + 1'b1;
            end
            if (hit) begin
               if (mode_ff == MODE_FREE) begin
                  busy_in[tag_ff] = 1'b0;
                  ok_in    = 1'b1;
                  state_in = ST_RESP;
               end else begin
                  s_in     = re + WB_A;
                  e_in     = re + WB_A + size_ff;
                  att_in   = att_ff + 1'b1;
                  state_in = ST_ATTEMPT;
               end
            end else if (pend_ff && tag_ff == LAST_IDX) begin
               if (mode_ff == MODE_ALLOC) begin
                  mem_we           = 1'b1;
                  busy_in[slot_ff] = 1'b1;
                  ok_in            = 1'b1;
                  off_in           = s_ff[OFF_W-1:0];
               end
               state_in = ST_RESP;
            end
         end
         ST_RESP: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[slot_ff] <= {s_ff[SW-1:0], e_ff[SW-1:0]};
      end
      if (rd_en) begin
         rdata_ff <= mem[iss_ff[IW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         busy_ff      <= '0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
         pend_ff  <= pend_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      mode_ff <= mode_in;
      req_ff  <= req_in;
      foff_ff <= foff_in;
      bit_ff  <= bit_in;
      size_ff <= size_in;
      s_ff    <= s_in;
      e_ff    <= e_in;
      slot_ff <= slot_in;
      att_ff  <= att_in;
      iss_ff  <= iss_in;
      tag_ff  <= tag_in;
      ok_ff   <= ok_in;
      off_ff  <= off_in;
      if (rsp_load) begin
         rsp_ok_ff  <= ok_ff;
         rsp_off_ff <= off_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_TD_W - OFF_W - 1)'(0), rsp_off_ff, rsp_ok_ff};

endmodule

// ----- dv/record_table_heap_allocator_tb.sv -----
// Self-checking testbench for the record table heap allocator: directed corners, then random traffic.
module record_table_heap_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rtha_pkg::*;

   localparam int RECORDS    = 16;
   localparam int HEAP_WORDS = 1024;
   localparam int WORD_BYTES = 4;
   localparam int HEAP_BYTES = HEAP_WORDS * WORD_BYTES;
   localparam int DRAIN_CYCLES = RECORDS * (RECORDS + 2) + 64;

   typedef struct packed {
      logic             ok;
      logic [OFF_W-1:0] offset;
   } outcome_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [REQ_TD_W-1:0] req_tdata = '0;    // req_bytes[12:0], free_offset[24:13], zero fill
   logic                req_tuser = MODE_ALLOC;  // mode
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_TD_W-1:0] rsp_tdata;        // ok[0], region_offset[12:1], zero fill

   int region_start [RECORDS];
   int region_end   [RECORDS];
   bit region_busy  [RECORDS];

   outcome_type pending_outcomes[$];

   bit steady = 1'b0;
   int hold_cycles = 0;
   int mismatches = 0;
   int placed_count = 0;
   int refused_count = 0;
   int freed_count = 0;
   int free_miss_count = 0;
   int request_count = 0;

   record_table_heap_allocator #(
      .RECORDS   (RECORDS),
      .HEAP_WORDS(HEAP_WORDS),
      .WORD_BYTES(WORD_BYTES)
   ) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata)
   );

   always #5 clock = ~clock;

   initial begin
      #20_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic int first_overlap(int s, int e);
      for (int i = 0; i < RECORDS; i++) begin
         if (region_busy[i] &&
             ((s <= region_start[i] && e >= region_start[i]) ||
              (s <= region_end[i] && e >= region_end[i]) ||
              (s >= region_start[i] && e <= region_end[i])))
            return i;
      end
      return -1;
   endfunction

   function automatic outcome_type apply_request(logic mode, logic [REQ_W-1:0] nbytes,
                                                 logic [OFF_W-1:0] foff);
      outcome_type r;
      int slot;
      int size;
      int s;
      int e;
      int hit;
      r = '0;
      if (mode == MODE_FREE) begin
         for (int i = 0; i < RECORDS; i++) begin
            if (region_busy[i] && region_start[i] == int'(foff)) begin
               region_busy[i] = 1'b0;
               r.ok = 1'b1;
               return r;
            end
         end
         return r;
      end
      slot = -1;
      for (int i = 0; i < RECORDS; i++) begin
         if (!region_busy[i]) begin
            slot = i;
            break;
         end
      end
      if (slot < 0)
         return r;
      size = ((int'(nbytes) + WORD_BYTES - 1) / WORD_BYTES) * WORD_BYTES;
      s = 0;
      e = size;
      for (int a = 0; a < RECORDS; a++) begin
         hit = first_overlap(s, e);
         if (e > HEAP_BYTES)
            return r;
         if (hit < 0) begin
            region_start[slot] = s;
            region_end[slot]   = e;
            region_busy[slot]  = 1'b1;
            r.ok     = 1'b1;
            r.offset = s[OFF_W-1:0];
            return r;
         end
         s = region_end[hit] + WORD_BYTES;
         e = s + size;
      end
      return r;
   endfunction

   // called just after a falling edge; returns just after a falling edge
   task automatic send_request(input logic mode, input logic [REQ_W-1:0] nbytes,
                               input logic [OFF_W-1:0] foff);
      outcome_type want;
      while (!steady && $urandom_range(99) < 15) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= mode;
      req_tdata  <= REQ_TD_W'({foff, nbytes});
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      want = apply_request(mode, nbytes, foff);
      pending_outcomes.push_back(want);
      request_count++;
      if (mode == MODE_ALLOC) begin
         if (want.ok) placed_count++;
         else refused_count++;
      end else begin
         if (want.ok) freed_count++;
         else free_miss_count++;
      end
      @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= 15);
      end
   end

   always @(posedge clock) begin
      outcome_type got;
      outcome_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.ok     = rsp_tdata[0];
         got.offset = rsp_tdata[OFF_W:1];
         if (pending_outcomes.size() == 0) begin
            $error("response with no request outstanding: ok=%0d region_offset=%0d",
                   got.ok, got.offset);
            mismatches++;
         end else begin
            want = pending_outcomes.pop_front();
            if (got.ok !== want.ok) begin
               $error("ok: expected %0d, actual %0d", want.ok, got.ok);
               mismatches++;
            end
            if (got.offset !== want.offset) begin
               $error("region_offset: expected %0d, actual %0d", want.offset, got.offset);
               mismatches++;
            end
         end
      end
   end

   function automatic logic [REQ_W-1:0] random_size();
      int pick;
      pick = $urandom_range(99);
      if (pick < 60) return REQ_W'($urandom_range(64));
      if (pick < 85) return REQ_W'($urandom_range(600));
      if (pick < 97) return REQ_W'($urandom_range(HEAP_BYTES));
      return REQ_W'($urandom_range(8191));
   endfunction

   // free offset: mostly the start of a live region, sometimes a stray address
   function automatic logic [OFF_W-1:0] pick_free_offset();
      int live[$];
      for (int i = 0; i < RECORDS; i++)
         if (region_busy[i] && region_start[i] < HEAP_BYTES)
            live.push_back(region_start[i]);
      if (live.size() > 0 && $urandom_range(99) < 75)
         return OFF_W'(live[$urandom_range(live.size() - 1)]);
      return OFF_W'($urandom_range(4095));
   endfunction

   function automatic int busy_count();
      int n;
      n = 0;
      for (int i = 0; i < RECORDS; i++)
         if (region_busy[i]) n++;
      return n;
   endfunction

   task automatic test_corner_cases();
      send_request(MODE_FREE,  13'd0,    12'd0);     // free on an empty table
      send_request(MODE_ALLOC, 13'd0,    12'hfff);   // zero size at offset 0
      send_request(MODE_ALLOC, 13'd0,    12'd0);     // zero size hits a point region
      send_request(MODE_ALLOC, 13'd1,    12'd0);     // rounds up, two hits
      send_request(MODE_ALLOC, 13'h1fff, 12'd0);     // larger than the heap
      send_request(MODE_FREE,  13'h1fff, 12'd4);
      send_request(MODE_FREE,  13'd0,    12'd4);     // already free
      send_request(MODE_FREE,  13'd0,    12'd0);
      send_request(MODE_FREE,  13'd0,    12'd8);
      send_request(MODE_ALLOC, 13'd4092, 12'd0);
      send_request(MODE_ALLOC, 13'd0,    12'd0);     // lands at the heap end, offset wraps
      send_request(MODE_ALLOC, 13'd0,    12'd0);     // bounds failure after two hits
      send_request(MODE_FREE,  13'd0,    12'd0);
      send_request(MODE_ALLOC, 13'd4095, 12'hfff);   // full heap size hits the end point
      send_request(MODE_FREE,  13'd0,    12'hfff);   // no match at the top address
   endtask

   task automatic test_table_full();
      for (int i = 0; i < RECORDS; i++)
         send_request(MODE_ALLOC, REQ_W'(i % 4), 12'd0);
      send_request(MODE_ALLOC, 13'd64, 12'd0);
      send_request(MODE_FREE, 13'd0, pick_free_offset());
      send_request(MODE_ALLOC, 13'd0, 12'd0);
   endtask

   task automatic test_random_traffic(input int count);
      int nb;
      int p_alloc;
      for (int n = 0; n < count; n++) begin
         nb = busy_count();
         p_alloc = (nb < 4) ? 80 : (nb > 12) ? 30 : 55;
         if ($urandom_range(99) < p_alloc)
            send_request(MODE_ALLOC, random_size(), OFF_W'($urandom_range(4095)));
         else
            send_request(MODE_FREE, REQ_W'($urandom_range(8191)), pick_free_offset());
      end
   endtask

   task automatic test_backpressure();
      hold_cycles = 600;
      test_random_traffic(12);
   endtask

   task automatic test_steady_stream(input int count);
      steady = 1'b1;
      test_random_traffic(count);
      steady = 1'b0;
   endtask

   initial begin
      repeat (11) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_corner_cases();
      test_table_full();
      test_backpressure();
      test_random_traffic(1050);
      test_steady_stream(250);
      req_tvalid <= 1'b0;
      while (pending_outcomes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d requests: %0d regions placed, %0d allocations refused,",
               request_count, placed_count, refused_count);
      $display("%0d frees matched, %0d frees missed; included a long response hold.",
               freed_count, free_miss_count);
      if (mismatches == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/rtha_pkg.sv
rtl/core/record_table_heap_allocator.sv
dv/record_table_heap_allocator_tb.sv
